>>> rtl/act_pkg.sv
package act_pkg;

	typedef enum logic [1:0] {
		OP_UPSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_PRUNE  = 2'd3
	} op_t;

	localparam logic [9:0] MsPerSecond = 10'd1000;

	localparam logic [1:0] ColorNone   = 2'd0;
	localparam logic [1:0] ColorYellow = 2'd1;
	localparam logic [1:0] ColorRed    = 2'd2;

	localparam logic [2:0] PatOff       = 3'd0;
	localparam logic [2:0] PatSolid     = 3'd1;
	localparam logic [2:0] PatSlow      = 3'd2;
	localparam logic [2:0] PatFast      = 3'd3;
	localparam logic [2:0] PatAlternate = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  source_id;
		logic [7:0]  condition_id;
		logic [1:0]  severity;
		logic [15:0] ttl_seconds;
		logic [31:0] now_ms;
	} req_item_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  entry_count;
		logic        top_valid;
		logic [7:0]  top_source;
		logic [7:0]  top_condition;
		logic [1:0]  top_severity;
		logic [1:0]  light_color;
		logic [2:0]  light_pattern;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] key;
		logic [1:0]  severity;
		logic [15:0] ttl;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [1:0] color;
		logic [2:0] pattern;
	} light_t;

	function automatic light_t light_for(input logic [1:0] sev);
		light_t l;
		case (sev)
			2'd0: l = '{ColorYellow, PatSolid};
			2'd1: l = '{ColorYellow, PatSlow};
			2'd2: l = '{ColorRed, PatFast};
			default: l = '{ColorNone, PatAlternate};
		endcase
		return l;
	endfunction

endpackage

>>> rtl/act_stream_if.sv
interface act_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/alarm_condition_table.sv
// Flow: clear, and any item but an upsert on an empty table, go straight to the result;
// else every stored entry is read and then evaluated, and an upsert with no match then
// appends its entry, if there is room, before the result is registered.
// Throughput: one item at a time, the next is accepted as soon as the result is registered;
// each item sweeps the entry memory through its single read port, entry by entry.
// Reset: arst_n clears the entry count and sets capacity to 16; entry memory is not cleared.
module alarm_condition_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [4:0]               cfg_wdata,
	act_stream_if.sink               req,
	act_stream_if.source             rsp
);
	import act_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [8:0] DepthW = 9'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EVAL, S_APPEND, S_DONE
	} state_t;

	state_t        state_q;
	logic [4:0]    cap_q;
	logic [CW-1:0] total_q, r_q, w_q;
	logic          found_q, ok_q;
	logic          top_v_q;
	logic [15:0]   top_key_q;
	logic [1:0]    top_sev_q;
	req_item_t     item_q;
	entry_t        rd_q;
	rsp_item_t     rsp_q;
	logic          rsp_valid_q;

	entry_t        mem [TABLE_DEPTH];

	entry_t        new_entry;
	logic          match, expired, keep, take_new, last;
	logic [31:0]   age;
	logic [25:0]   limit;
	logic [8:0]    cap_eff;
	logic          room;
	entry_t        keep_data;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;
	light_t        light;

	always_comb begin
		new_entry = '{{item_q.source_id, item_q.condition_id}, item_q.severity,
			item_q.ttl_seconds, item_q.now_ms};
		match     = (rd_q.key == new_entry.key) && !found_q;
		age       = item_q.now_ms - rd_q.stamp;
		limit     = 26'(rd_q.ttl) * 26'(MsPerSecond);
		expired   = (rd_q.ttl != 16'd0) && (age >= {6'd0, limit});
		take_new  = (item_q.op == OP_UPSERT) && match;
		case (item_q.op)
			OP_REMOVE: keep = !match;
			OP_PRUNE:  keep = !expired;
			default:   keep = 1'b1;
		endcase
		keep_data = take_new ? new_entry : rd_q;
		last      = (r_q + CW'(1)) == total_q;
		cap_eff   = (9'(cap_q) > DepthW) ? DepthW : 9'(cap_q);
		room      = 9'(total_q) < cap_eff;
		mem_we    = 1'b0;
		mem_wa    = w_q[IW-1:0];
		mem_wd    = keep_data;
		if (state_q == S_EVAL && keep) begin
			mem_we = 1'b1;
		end else if (state_q == S_APPEND && room) begin
			mem_we = 1'b1;
			mem_wa = total_q[IW-1:0];
			mem_wd = new_entry;
		end
		light = top_v_q ? light_for(top_sev_q) : '{ColorNone, PatOff};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_READ) begin
			rd_q <= mem[r_q[IW-1:0]];
		end
		if (req.valid && req.ready) begin
			item_q <= req.data;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= 5'd16;
			total_q     <= '0;
			r_q         <= '0;
			w_q         <= '0;
			found_q     <= 1'b0;
			ok_q        <= 1'b0;
			top_v_q     <= 1'b0;
			top_key_q   <= '0;
			top_sev_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						r_q     <= '0;
						w_q     <= '0;
						found_q <= 1'b0;
						ok_q    <= 1'b0;
						top_v_q <= 1'b0;
						if (req.data.op == OP_CLEAR) begin
							total_q <= '0;
							state_q <= S_DONE;
						end else if (total_q != '0) begin
							state_q <= S_READ;
						end else if (req.data.op == OP_UPSERT) begin
							state_q <= S_APPEND;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (match && (item_q.op == OP_UPSERT || item_q.op == OP_REMOVE)) begin
						found_q <= 1'b1;
						ok_q    <= 1'b1;
					end
					// Kept entries arrive in table order, so a strict compare keeps
					// the earliest entry among equal severities.
					if (keep) begin
						w_q <= w_q + CW'(1);
						if (!top_v_q || keep_data.severity > top_sev_q) begin
							top_v_q   <= 1'b1;
							top_key_q <= keep_data.key;
							top_sev_q <= keep_data.severity;
						end
					end
					r_q <= r_q + CW'(1);
					if (last) begin
						total_q <= keep ? w_q + CW'(1) : w_q;
						if (item_q.op == OP_UPSERT && !match && !found_q) begin
							state_q <= S_APPEND;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_READ;
					end
				end
				S_APPEND: begin
					if (room) begin
						total_q <= total_q + CW'(1);
						ok_q    <= 1'b1;
						if (!top_v_q || item_q.severity > top_sev_q) begin
							top_v_q   <= 1'b1;
							top_key_q <= new_entry.key;
							top_sev_q <= item_q.severity;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.ok            <= ok_q;
						rsp_q.entry_count   <= 5'(total_q);
						rsp_q.top_valid     <= top_v_q;
						rsp_q.top_source    <= top_v_q ? top_key_q[15:8] : 8'd0;
						rsp_q.top_condition <= top_v_q ? top_key_q[7:0] : 8'd0;
						rsp_q.top_severity  <= top_v_q ? top_sev_q : 2'd0;
						rsp_q.light_color   <= light.color;
						rsp_q.light_pattern <= light.pattern;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= TABLE_DEPTH)
		else $error("entry count exceeds table depth");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> (w_q <= r_q))
		else $error("compaction write overtook the read pointer");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.top_valid) |->
		(rsp_q.top_severity == 2'd0 && rsp_q.light_color == ColorNone &&
		 rsp_q.light_pattern == PatOff))
		else $error("empty table reports a top entry");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item accepted while one is at work");

endmodule
